/* design/h264_nal_unit_scanner_defines.svh */
// Assertion macros shared by the NAL unit scanner modules.
// Needs a clk and an active-low arst_n in the including module's scope.
`ifndef H264_NAL_UNIT_SCANNER_DEFINES_SVH
`define H264_NAL_UNIT_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HNUS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HNUS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/hnus_pkg.sv */
// Shared types and constants for the H.264 NAL unit scanner.
// No dependencies; imported by every scanner module.
package hnus_pkg;

	localparam int POS_W = 24;
	localparam longint MAX_BUFFER_BYTES = 64'd16777216;
	localparam longint POS_LIMIT = 64'hFFFFFF;
	localparam logic [POS_W-1:0] POS_CAP =
		POS_W'((MAX_BUFFER_BYTES - 1 > POS_LIMIT) ? POS_LIMIT : MAX_BUFFER_BYTES - 1);

	localparam logic [4:0] NAL_SPS    = 5'd7;
	localparam logic [4:0] NAL_PPS    = 5'd8;
	localparam logic [7:0] START_BYTE = 8'h01;
	localparam logic [1:0] ZRUN_MAX   = 2'd3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// First member is the top bit: unit_valid ends up at bit 0.
	typedef struct packed {
		logic [POS_W-1:0] pps_size;
		logic [POS_W-1:0] pps_pos;
		logic [POS_W-1:0] sps_size;
		logic [POS_W-1:0] sps_pos;
		logic             params_found;
		logic [POS_W-1:0] unit_size;
		logic             ref_flag;
		logic [4:0]       unit_type;
		logic [POS_W-1:0] payload_pos;
		logic [POS_W-1:0] start_pos;
		logic             unit_valid;
	} out_word_t;

	typedef struct packed {
		logic      last;
		out_word_t word;
	} res_t;

	// One classified byte: one or two result words.
	typedef struct packed {
		logic two;
		res_t first;
		res_t second;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_push_t;

	typedef struct packed {
		logic             valid;
		logic [POS_W-1:0] start_pos;
		logic [POS_W-1:0] payload_pos;
		logic [4:0]       unit_type;
		logic             ref_flag;
	} pend_t;

endpackage

/* design/h264_nal_unit_scanner.sv */
// H.264 Annex B NAL unit scanner, top level.
// Channels: s_* takes one stream byte per word, s_tlast on the buffer's final byte.
//   m_* gives one word per NAL unit, sent once its size is known (at the next
//   start code's header byte or at buffer end); the buffer's final word has
//   m_tlast high and carries the SPS/PPS summary. An empty buffer still gives
//   one final word, with unit_valid low.
// Path: the closing byte's entry is written into the queue when the byte is
//   accepted and then moves into the output register, from which its word is
//   sent; a second word from the same byte follows it out of that register.
// Throughput: one byte per cycle while the queue is not full; an ending byte that
//   closes two units gives two output words, and the byte scan stalls when the queue is full.
// Front: start-code tracking, unit bookkeeping, size and record updates.
// Queue: two entries of classified bytes, each holding one or two result words.
// Back: output register that sends an entry's words in order.
// A stalled receiver fills the output register, then the queue; s_tready drops
//   only when the queue is full.
// Reset (arst_n low) clears the scan state, the queue and the output valid.
// After a buffer's final byte all scan state returns to its reset value.
module h264_nal_unit_scanner import hnus_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tlast,   // end_of_buffer
	output logic         m_tvalid,
	input  logic         m_tready,
	// [0] unit_valid, [24:1] start_pos, [48:25] payload_pos, [53:49] unit_type,
	// [54] ref_flag, [78:55] unit_size, [79] params_found, [103:80] sps_pos,
	// [127:104] sps_size, [151:128] pps_pos, [175:152] pps_size
	output logic [175:0] m_tdata,
	output logic         m_tlast    // last
);

	q_push_t  push;
	q_entry_t head;
	logic     q_full, q_empty, q_pop;

	// Classify each byte and hand closed units to the queue.
	hnus_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (push)
	);

	// Decouple the scan from output stalls.
	hnus_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (q_pop),
		.full   (q_full),
		.empty  (q_empty),
		.head   (head)
	);

	// Send each entry's words, first before second.
	hnus_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.head     (head),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

/* design/hnus_front.sv */
// Front end of the NAL unit scanner: start-code detection and unit bookkeeping.
// Depends on hnus_pkg and the assertion macros header.
`include "h264_nal_unit_scanner_defines.svh"

module hnus_front import hnus_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tlast,
	input  logic       q_full,
	output q_push_t    push
);

	logic [POS_W-1:0] pos_q;
	logic [1:0]       zr_q;
	logic             hdr_q;
	logic [POS_W-1:0] nstart_q;
	pend_t            pend_q;
	logic             sps_seen_q, pps_seen_q;
	logic [POS_W-1:0] sps_pos_q, sps_size_q, pps_pos_q, pps_size_q;

	logic             accept;
	logic             emit_a;
	logic [POS_W-1:0] size_a;
	res_t             res_a, res_f;
	pend_t            pend_n;
	logic             sps_seen_a, pps_seen_a, sps_seen_f, pps_seen_f;
	logic [POS_W-1:0] sps_pos_a, sps_size_a, pps_pos_a, pps_size_a;
	logic [POS_W-1:0] sps_pos_f, sps_size_f, pps_pos_f, pps_size_f;
	logic [POS_W:0]   len_f, diff_f;
	logic [POS_W-1:0] size_f;
	logic             start_hit;
	logic [POS_W-1:0] back_n;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		// Unit closed by the header byte of a new start code.
		emit_a = hdr_q && pend_q.valid;
		size_a = (nstart_q >= pend_q.payload_pos) ? nstart_q - pend_q.payload_pos : '0;
		res_a = '0;
		res_a.word.unit_valid  = 1'b1;
		res_a.word.start_pos   = pend_q.start_pos;
		res_a.word.payload_pos = pend_q.payload_pos;
		res_a.word.unit_type   = pend_q.unit_type;
		res_a.word.ref_flag    = pend_q.ref_flag;
		res_a.word.unit_size   = size_a;
		sps_seen_a = sps_seen_q;
		pps_seen_a = pps_seen_q;
		sps_pos_a  = sps_pos_q;
		sps_size_a = sps_size_q;
		pps_pos_a  = pps_pos_q;
		pps_size_a = pps_size_q;
		if (emit_a && pend_q.unit_type == NAL_SPS) begin
			sps_seen_a = 1'b1;
			sps_pos_a  = pend_q.payload_pos;
			sps_size_a = size_a;
		end else if (emit_a && pend_q.unit_type == NAL_PPS) begin
			pps_seen_a = 1'b1;
			pps_pos_a  = pend_q.payload_pos;
			pps_size_a = size_a;
		end

		// Open a new unit on its header byte.
		pend_n = pend_q;
		if (hdr_q) begin
			pend_n.valid       = 1'b1;
			pend_n.start_pos   = nstart_q;
			pend_n.payload_pos = pos_q;
			pend_n.unit_type   = s_tdata[4:0];
			pend_n.ref_flag    = s_tdata[5];
		end

		// Final word of the buffer.
		len_f  = {1'b0, pos_q} + (POS_W+1)'(1);
		diff_f = len_f - {1'b0, pend_n.payload_pos};
		size_f = diff_f[POS_W] ? '1 : diff_f[POS_W-1:0];
		sps_seen_f = sps_seen_a;
		pps_seen_f = pps_seen_a;
		sps_pos_f  = sps_pos_a;
		sps_size_f = sps_size_a;
		pps_pos_f  = pps_pos_a;
		pps_size_f = pps_size_a;
		res_f = '0;
		if (pend_n.valid) begin
			res_f.word.unit_valid  = 1'b1;
			res_f.word.start_pos   = pend_n.start_pos;
			res_f.word.payload_pos = pend_n.payload_pos;
			res_f.word.unit_type   = pend_n.unit_type;
			res_f.word.ref_flag    = pend_n.ref_flag;
			res_f.word.unit_size   = size_f;
			if (pend_n.unit_type == NAL_SPS) begin
				sps_seen_f = 1'b1;
				sps_pos_f  = pend_n.payload_pos;
				sps_size_f = size_f;
			end else if (pend_n.unit_type == NAL_PPS) begin
				pps_seen_f = 1'b1;
				pps_pos_f  = pend_n.payload_pos;
				pps_size_f = size_f;
			end
		end
		res_f.word.params_found = sps_seen_f && pps_seen_f;
		res_f.word.sps_pos      = sps_pos_f;
		res_f.word.sps_size     = sps_size_f;
		res_f.word.pps_pos      = pps_pos_f;
		res_f.word.pps_size     = pps_size_f;
		res_f.last              = 1'b1;

		// Start code ends on this byte; its header must still lie in the buffer.
		start_hit = (s_tdata == START_BYTE) && (zr_q >= 2'd2) && !s_tlast;
		back_n    = (zr_q == ZRUN_MAX) ? POS_W'(3) : POS_W'(2);

		push.valid        = accept && (emit_a || s_tlast);
		push.entry.two    = emit_a && s_tlast;
		push.entry.first  = emit_a ? res_a : res_f;
		push.entry.second = res_f;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			zr_q       <= '0;
			hdr_q      <= 1'b0;
			nstart_q   <= '0;
			pend_q     <= '0;
			sps_seen_q <= 1'b0;
			pps_seen_q <= 1'b0;
			sps_pos_q  <= '0;
			sps_size_q <= '0;
			pps_pos_q  <= '0;
			pps_size_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				// Drop all state: each buffer is scanned on its own.
				pos_q      <= '0;
				zr_q       <= '0;
				hdr_q      <= 1'b0;
				nstart_q   <= '0;
				pend_q     <= '0;
				sps_seen_q <= 1'b0;
				pps_seen_q <= 1'b0;
				sps_pos_q  <= '0;
				sps_size_q <= '0;
				pps_pos_q  <= '0;
				pps_size_q <= '0;
			end else begin
				pos_q      <= (pos_q == POS_CAP) ? POS_CAP : pos_q + POS_W'(1);
				hdr_q      <= start_hit;
				if (start_hit) begin
					nstart_q <= (pos_q >= back_n) ? pos_q - back_n : '0;
				end
				if (s_tdata == 8'h00) begin
					zr_q <= (zr_q == ZRUN_MAX) ? ZRUN_MAX : zr_q + 2'd1;
				end else begin
					zr_q <= '0;
				end
				pend_q     <= pend_n;
				sps_seen_q <= sps_seen_a;
				pps_seen_q <= pps_seen_a;
				sps_pos_q  <= sps_pos_a;
				sps_size_q <= sps_size_a;
				pps_pos_q  <= pps_pos_a;
				pps_size_q <= pps_size_a;
			end
		end
	end

	`HNUS_ASSERT_NXT(a_pos_cleared, accept && s_tlast, pos_q == '0, "position not cleared after buffer end")
	`HNUS_ASSERT_IMP(a_hdr_zero_run, hdr_q, zr_q == '0, "zero run not cleared by start code")

endmodule

/* design/hnus_queue.sv */
// Short queue of classified bytes between scanner front and back.
// Depends on hnus_pkg and the assertion macros header.
`include "h264_nal_unit_scanner_defines.svh"

module hnus_queue import hnus_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  q_push_t  push,
	input  logic     pop,
	output logic     full,
	output logic     empty,
	output q_entry_t head
);

	q_entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push.valid && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push.valid) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	`HNUS_ASSERT_IMP(a_no_overflow, push.valid, !full, "push into full queue")
	`HNUS_ASSERT_IMP(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

/* design/hnus_back.sv */
// Back end of the NAL unit scanner: serialises queue entries onto the output stream.
// Depends on hnus_pkg and the assertion macros header.
`include "h264_nal_unit_scanner_defines.svh"

module hnus_back import hnus_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  q_entry_t       head,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [175:0]   m_tdata,
	output logic           m_tlast
);

	logic      out_valid_q;
	res_t      out_q;
	logic      hold2_q;
	res_t      second_q;
	logic      out_free;

	assign out_free = !out_valid_q || m_tready;
	assign pop      = out_free && !hold2_q && !empty;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.word;
	assign m_tlast  = out_q.last;

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (hold2_q) begin
				out_q <= second_q;
			end else if (!empty) begin
				out_q    <= head.first;
				second_q <= head.second;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hold2_q     <= 1'b0;
		end else if (out_free) begin
			if (hold2_q) begin
				out_valid_q <= 1'b1;
				hold2_q     <= 1'b0;
			end else begin
				out_valid_q <= !empty;
				hold2_q     <= !empty && head.two;
			end
		end
	end

	`HNUS_ASSERT_IMP(a_hold_has_word, hold2_q, out_valid_q, "second word held without a first")

endmodule
